// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold at every clock edge out of reset
`define CHK_ALWAYS(label, clk_s, rst_s, expr, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (expr)) else $error(msg);
// implication checked at every clock edge out of reset
`define CHK_IMPLY(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
`endif

// ----- hdl/aabb_pkg.sv -----
// package for the aabb gravity collision step block
// constants, record types and fixed-point helpers; no dependencies
package aabb_pkg;

    localparam int MaxBoxes = 64;
    localparam int SlotW = $clog2(MaxBoxes);
    localparam int CntW = $clog2(MaxBoxes + 1);
    localparam logic signed [31:0] EpsQ16 = 32'sd7;
    localparam logic signed [31:0] GravityRst = 32'sd642908;
    localparam logic [30:0] TimeStepRst = 31'd1092;

    localparam logic RegGravity = 1'b0;
    localparam logic RegTimeStep = 1'b1;

    localparam logic OpLoad = 1'b0;
    localparam logic OpStep = 1'b1;

    // one static box
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [30:0] w;
        logic [30:0] h;
    } box_t;

    // body state travelling down the cell chain
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vel;
        logic landed;
    } body_t;

    // saturate a 34-bit sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (v < -34'sh0_8000_0000)
            return 32'sh8000_0000;
        else
            return v[31:0];
    endfunction

    // floor shift by 16 of a 64-bit product, then saturate
    function automatic logic signed [31:0] qsat(input logic signed [63:0] p);
        logic signed [47:0] s;
        s = 48'(p >>> 16);
        if (s > 48'sh0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        else if (s < -48'sh0000_8000_0000)
            return 32'sh8000_0000;
        else
            return s[31:0];
    endfunction

endpackage

// ----- hdl/aabb_gravity_collision_step.sv -----
// top level of the aabb gravity collision step block
// depends on aabb_pkg and aabb_cell
//
// A chain of 64 cells, each holding one static box, resolves a moving body
// against every box in slot order. An op 0 transaction loads one cell and
// gives no result. An op 1 transaction runs: gravity (ST_GRAV1, ST_GRAV2),
// x move (ST_MOVEX), x pass down the chain (ST_CHAINX), y move (ST_MOVEY),
// y pass (ST_CHAINY), then the result register (ST_OUT). One body is in
// flight at a time. Gravity is skipped for a static body or one without a
// rigid body, and both chain passes for a body without a rigid body. The
// next transaction can be accepted once the result is registered and the
// block is idle again, so the step rate is set by the two walks along the
// 64-cell chain. The result register frees the input side, so a stalled
// result only holds back the next result, not the next transaction. Load
// transactions leave the block idle.
module aabb_gravity_collision_step (
    input  logic         clk,
    input  logic         rst_n,
    // configuration write port
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // op, slot, pos_x, pos_y, vel_x, vel_y, box_w, box_h, mass, is_static,
    // has_body, has_ground_flag from bit 0 up (bit 231 unused)
    input  logic [231:0] s_tdata,
    // output stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x, new_pos_y, new_vel_x, new_vel_y from bit 0 up
    output logic [127:0] m_tdata,
    // grounded
    output logic         m_tuser
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_GRAV1, ST_GRAV2, ST_MOVEX, ST_CHAINX, ST_MOVEY, ST_CHAINY, ST_OUT
    } state_t;

    localparam int N = aabb_pkg::MaxBoxes;

    // input field split
    logic op_in;
    logic [5:0] slot_in;
    logic signed [31:0] px_in, py_in, vx_in, vy_in;
    logic [30:0] w_in, h_in, m_in;
    logic st_in, hb_in, gf_in;
    assign op_in   = s_tdata[0];
    assign slot_in = s_tdata[6:1];
    assign px_in   = s_tdata[38:7];
    assign py_in   = s_tdata[70:39];
    assign vx_in   = s_tdata[102:71];
    assign vy_in   = s_tdata[134:103];
    assign w_in    = s_tdata[165:135];
    assign h_in    = s_tdata[196:166];
    assign m_in    = s_tdata[227:197];
    assign st_in   = s_tdata[228];
    assign hb_in   = s_tdata[229];
    assign gf_in   = s_tdata[230];

    logic signed [31:0] gravity_reg;
    logic [30:0] tstep_reg;
    state_t state_reg;
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, acc_reg;
    logic [30:0] w_reg, h_reg, m_reg;
    logic hb_reg, gf_reg, landed_reg;
    logic out_vld_reg;
    logic [127:0] out_data_reg;
    logic out_user_reg;

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // shared multiply: vel * time_step, or the gravity products
    logic signed [63:0] prod;
    logic signed [31:0] mv_pos;

    // chain wiring
    logic            vld_w [N+1];
    aabb_pkg::body_t body_w [N+1];
    aabb_pkg::box_t  wr_box;
    logic axis;
    // the first cell sees the body in the move cycle, so the y pass starts there
    assign axis = (state_reg == ST_MOVEY) || (state_reg == ST_CHAINY);
    assign wr_box = '{x: px_in, y: py_in, w: w_in, h: h_in};

    // the body enters the chain with the state it had after the move
    assign vld_w[0]  = (state_reg == ST_MOVEX || state_reg == ST_MOVEY) && hb_reg;
    always_comb
    begin
        body_w[0].px     = (state_reg == ST_MOVEX) ? mv_pos : px_reg;
        body_w[0].py     = (state_reg == ST_MOVEY) ? mv_pos : py_reg;
        body_w[0].vel    = (state_reg == ST_MOVEX) ? vx_reg : vy_reg;
        body_w[0].landed = landed_reg;
    end

    always_comb
    begin
        unique case (state_reg)
            ST_GRAV1: prod = 64'(gravity_reg) * 64'($signed({1'b0, m_reg}));
            ST_GRAV2: prod = 64'(acc_reg) * 64'($signed({1'b0, tstep_reg}));
            ST_MOVEX: prod = 64'(vx_reg) * 64'($signed({1'b0, tstep_reg}));
            default:  prod = 64'(vy_reg) * 64'($signed({1'b0, tstep_reg}));
        endcase
        mv_pos = aabb_pkg::sat34(34'((state_reg == ST_MOVEX) ? px_reg : py_reg)
            + 34'(aabb_pkg::qsat(prod)));
    end

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            aabb_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .wr      (accept && op_in == aabb_pkg::OpLoad
                          && slot_in == aabb_pkg::SlotW'(gi)),
                .wr_box  (wr_box),
                .axis    (axis),
                .bw      (w_reg),
                .bh      (h_reg),
                .in_vld  (vld_w[gi]),
                .in_body (body_w[gi]),
                .out_vld (vld_w[gi+1]),
                .out_body(body_w[gi+1])
            );
        end
    endgenerate

    logic [aabb_pkg::CntW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gravity_reg <= aabb_pkg::GravityRst;
            tstep_reg   <= aabb_pkg::TimeStepRst;
            state_reg   <= ST_IDLE;
            out_vld_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    aabb_pkg::RegGravity:  gravity_reg <= cfg_data;
                    aabb_pkg::RegTimeStep: tstep_reg <= cfg_data[30:0];
                    default: ;
                endcase
            end
            if (out_vld_reg && m_tready)
                out_vld_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept && op_in == aabb_pkg::OpStep)
                        state_reg <= (hb_in && !st_in) ? ST_GRAV1 : ST_MOVEX;
                end
                ST_GRAV1: state_reg <= ST_GRAV2;
                ST_GRAV2: state_reg <= ST_MOVEX;
                ST_MOVEX:
                begin
                    cnt_reg   <= '0;
                    state_reg <= hb_reg ? ST_CHAINX : ST_MOVEY;
                end
                ST_CHAINX:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == aabb_pkg::CntW'(N - 1))
                        state_reg <= ST_MOVEY;
                end
                ST_MOVEY:
                begin
                    cnt_reg   <= '0;
                    state_reg <= hb_reg ? ST_CHAINY : ST_OUT;
                end
                ST_CHAINY:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == aabb_pkg::CntW'(N - 1))
                        state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    // wait here while the previous result is still unread
                    if (!out_vld_reg)
                    begin
                        out_vld_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // body working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                px_reg <= px_in; py_reg <= py_in;
                vx_reg <= vx_in; vy_reg <= vy_in;
                w_reg <= w_in; h_reg <= h_in; m_reg <= m_in;
                hb_reg <= hb_in; gf_reg <= gf_in;
                landed_reg <= 1'b0;
            end
            ST_GRAV1: acc_reg <= aabb_pkg::qsat(prod);
            ST_GRAV2: vy_reg <= aabb_pkg::sat34(34'(vy_reg) + 34'(aabb_pkg::qsat(prod)));
            ST_MOVEX: px_reg <= mv_pos;
            ST_MOVEY: py_reg <= mv_pos;
            ST_OUT:
            begin
                if (!out_vld_reg)
                begin
                    out_data_reg <= {vy_reg, vx_reg, py_reg, px_reg};
                    out_user_reg <= landed_reg && gf_reg;
                end
            end
            default: ;
        endcase
        // chain end: pick up the resolved body
        if (vld_w[N] && cnt_reg == aabb_pkg::CntW'(N - 1))
        begin
            px_reg     <= body_w[N].px;
            py_reg     <= body_w[N].py;
            landed_reg <= body_w[N].landed;
            if (state_reg == ST_CHAINX)
                vx_reg <= body_w[N].vel;
            else
                vy_reg <= body_w[N].vel;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- hdl/aabb_cell.sv -----
// one resolve cell of the chain: holds one static box and resolves the body on it
// depends on aabb_pkg
module aabb_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr,
    input  aabb_pkg::box_t    wr_box,
    input  logic              axis,
    input  logic [30:0]       bw,
    input  logic [30:0]       bh,
    input  logic              in_vld,
    input  aabb_pkg::body_t   in_body,
    output logic              out_vld,
    output aabb_pkg::body_t   out_body
);

    aabb_pkg::box_t box_reg;
    logic vld_reg;
    aabb_pkg::body_t body_reg;
    aabb_pkg::body_t body_next;

    logic signed [33:0] lx, ly, bx, by, hx, hy, bhx, bhy;
    logic signed [33:0] lox, hix, loy, hiy, ox, oy, o, p;
    logic signed [33:0] np;

    always_comb
    begin
        lx  = 34'(in_body.px) - 34'(bw >> 1);
        ly  = 34'(in_body.py) - 34'(bh >> 1);
        hx  = lx + 34'(bw);
        hy  = ly + 34'(bh);
        bx  = 34'(box_reg.x) - 34'(box_reg.w >> 1);
        by  = 34'(box_reg.y) - 34'(box_reg.h >> 1);
        bhx = bx + 34'(box_reg.w);
        bhy = by + 34'(box_reg.h);
        lox = (lx > bx) ? lx : bx;
        hix = (hx < bhx) ? hx : bhx;
        loy = (ly > by) ? ly : by;
        hiy = (hy < bhy) ? hy : bhy;
        ox  = (hix > lox) ? hix - lox : 34'sd0;
        oy  = (hiy > loy) ? hiy - loy : 34'sd0;
        o   = axis ? oy : ox;
        p   = axis ? 34'(in_body.py) : 34'(in_body.px);
        body_next = in_body;
        np = (in_body.vel > 0) ? p - o - 34'(aabb_pkg::EpsQ16) : p + o;
        if (ox > 0 && oy > 0)
        begin
            if (axis)
                body_next.py = aabb_pkg::sat34(np);
            else
                body_next.px = aabb_pkg::sat34(np);
            if (axis && in_body.vel > 0)
                body_next.landed = 1'b1;
            body_next.vel = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
            vld_reg <= 1'b0;
        end
        else
        begin
            if (wr)
                box_reg <= wr_box;
            vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg <= body_next;
    end

    assign out_vld  = vld_reg;
    assign out_body = body_reg;

endmodule

// ----- hdl/aabb_checker.sv -----
// port-level checker for the aabb gravity collision step block
// depends on assert_macros.svh; bound to the top level
`include "assert_macros.svh"
module aabb_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);
    // a stalled result keeps its contents
    `CHK_IMPLY(a_data_hold, clk, rst_n, m_tvalid && !m_tready, ##1 $stable({m_tdata, m_tuser}), "result changed while stalled")
    // a stalled result stays valid
    `CHK_IMPLY(a_hold, clk, rst_n, m_tvalid && !m_tready, ##1 m_tvalid, "result dropped")
    // after an accepted result the output side does not present it twice
    `CHK_IMPLY(a_once, clk, rst_n, m_tvalid && m_tready, ##1 !m_tvalid, "result repeated")
endmodule

bind aabb_gravity_collision_step aabb_checker u_chk (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
